[rtl/core/multi_circular_deque_unit_assert.svh]
// Assertion macros for the multi circular deque unit.
`ifndef MULTI_CIRCULAR_DEQUE_UNIT_ASSERT_SVH
`define MULTI_CIRCULAR_DEQUE_UNIT_ASSERT_SVH

// Same-cycle implication, reset disables the check.
`define MCDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset disables the check.
`define MCDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define MCDQ_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mcdq_pkg.sv]
// Shared codes, widths and types of the multi circular deque unit.
package mcdq_pkg;

  localparam int OP_W    = 3;
  localparam int SEL_W   = 2;
  localparam int WORD_W  = 32;
  localparam int INDEX_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

endpackage

[rtl/core/multi_circular_deque_unit.sv]
// Multi circular deque unit: several deques sharing one entry memory.
//
// Use:
//   Commands enter on start/operation/queue_select/value and are taken at a
//   clock edge where start is high and busy is low. Results leave on the
//   result ports, one beat per cycle marked by strobe; the receiver must take
//   every beat, there is no back-pressure on the result side.
// Command flow:
//   Push front/back and pop front/back give no beat; busy stays low so a
//   new command can follow in the next cycle.
//   A dump keeps busy high while it reads the deque's entries from the entry
//   memory, one read per cycle, and then gives the closing beat (last, head
//   and tail pointers) in the cycle after the final entry beat; the next
//   command is taken once busy falls again.
// Reset:
//   rst clears every head, tail and full flag and returns the sequencer to
//   idle. The entry memory is not cleared; entries are only listed once they
//   have been written, so no clearing pass is needed.
module multi_circular_deque_unit
  import mcdq_pkg::*;
#(
  parameter int DEPTH      = 8,
  parameter int NUM_QUEUES = 3,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [OP_W-1:0]           operation,
  input  logic [SEL_W-1:0]          queue_select,
  input  logic signed [WORD_W-1:0]  value,
  output logic                      strobe,
  output logic signed [WORD_W-1:0]  element_value,
  output logic                      element_valid,
  output logic [INDEX_W-1:0]        head_index,
  output logic [INDEX_W-1:0]        tail_index,
  output logic                      last
);

  // Pointer, count, queue and memory address widths.
  localparam int PW  = $clog2(DEPTH);
  localparam int CW  = PW + 1;
  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int ENTRIES = NUM_QUEUES * DEPTH;
  localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? PW'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [AW-1:0] entry_addr(input logic [QW-1:0] q,
                                               input logic [PW-1:0] p);
    entry_addr = AW'(int'(q) * DEPTH + int'(p));
  endfunction

  // Per-queue control state.
  logic [PW-1:0] head [NUM_QUEUES];
  logic [PW-1:0] tail [NUM_QUEUES];
  logic          full [NUM_QUEUES];

  // Entry memory, one write and one registered read port.
  logic [DATA_WIDTH-1:0] mem [ENTRIES];
  logic [DATA_WIDTH-1:0] rd_data;

  state_t        state;
  logic [QW-1:0] dq;          // queue being dumped
  logic [PW-1:0] didx;        // next entry to read
  logic [CW-1:0] remain;      // entries still to read
  logic [PW-1:0] dh, dt;      // pointers captured for the closing beat
  logic          ent_pend;    // rd_data holds a listed entry this cycle
  logic          fin_pend;    // closing beat this cycle

  // Command decode.
  logic          accept;
  logic          q_ok;
  logic [QW-1:0] qs;
  logic [PW-1:0] ch, ct, ch_dec, ct_inc;
  logic          cfull, cempty;
  logic [CW-1:0] ccount;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [63:0]           value_ext;

  assign accept = start && !busy;
  assign q_ok   = int'(queue_select) < NUM_QUEUES;
  assign qs     = QW'(queue_select);
  assign ch     = head[qs];
  assign ct     = tail[qs];
  assign cfull  = full[qs];
  assign cempty = (ch == ct) && !cfull;
  assign ch_dec = ptr_dec(ch);
  assign ct_inc = ptr_inc(ct);

  // Fill level: a full deque lists every entry.
  always_comb begin
    if (cfull) begin
      ccount = CW'(DEPTH);
    end else if (ct >= ch) begin
      ccount = CW'(ct) - CW'(ch);
    end else begin
      ccount = CW'(ct) + CW'(DEPTH) - CW'(ch);
    end
  end

  assign value_ext = {32'b0, value};
  assign wr_data   = value_ext[DATA_WIDTH-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = entry_addr(qs, ct);
    if (accept && q_ok && !cfull) begin
      case (operation)
        OP_PUSH_BACK: begin
          wr_en   = 1'b1;
          wr_addr = entry_addr(qs, ct);
        end
        OP_PUSH_FRONT: begin
          wr_en   = 1'b1;
          wr_addr = entry_addr(qs, ch_dec);
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  assign rd_en = (state == ST_DUMP) && (remain != '0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[entry_addr(dq, didx)];
    end
  end

  // Pointer updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        full[i] <= 1'b0;
      end
    end else if (accept && q_ok) begin
      case (operation)
        OP_PUSH_BACK: begin
          if (!cfull) begin
            tail[qs] <= ct_inc;
            if (ct_inc == ch) full[qs] <= 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (!cempty) begin
            head[qs] <= ptr_inc(ch);
            full[qs] <= 1'b0;
          end
        end
        OP_PUSH_FRONT: begin
          if (!cfull) begin
            head[qs] <= ch_dec;
            if (ch_dec == ct) full[qs] <= 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (!cempty) begin
            tail[qs] <= ptr_dec(ct);
            full[qs] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Dump sequencer: one memory read per cycle, then the closing beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ent_pend <= 1'b0;
      fin_pend <= 1'b0;
    end else begin
      ent_pend <= 1'b0;
      fin_pend <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && q_ok && (operation == OP_DUMP)) begin
            state <= ST_DUMP;
          end
        end
        ST_DUMP: begin
          if (remain != '0) begin
            ent_pend <= 1'b1;
          end else begin
            fin_pend <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Dump payload registers.
  always_ff @(posedge clk) begin
    if (accept && q_ok && (operation == OP_DUMP)) begin
      dq     <= qs;
      didx   <= ch;
      remain <= ccount;
      dh     <= ch;
      dt     <= ct;
    end else if (rd_en) begin
      didx   <= ptr_inc(didx);
      remain <= remain - 1'b1;
    end
  end

  assign busy = (state != ST_IDLE);

  // Result beat.
  logic signed [63:0]   rd_ext;
  logic [PW+INDEX_W-1:0] dh_ext, dt_ext;

  assign rd_ext = 64'(signed'(rd_data));
  assign dh_ext = {{INDEX_W{1'b0}}, dh};
  assign dt_ext = {{INDEX_W{1'b0}}, dt};

  assign strobe        = ent_pend | fin_pend;
  assign element_valid = ent_pend;
  assign last          = fin_pend;
  assign element_value = ent_pend ? rd_ext[WORD_W-1:0] : '0;
  assign head_index    = fin_pend ? dh_ext[INDEX_W-1:0] : '0;
  assign tail_index    = fin_pend ? dt_ext[INDEX_W-1:0] : '0;

endmodule

[rtl/core/mcdq_checker.sv]
// Port-level checks of the multi circular deque unit, bound to the top level.
`include "multi_circular_deque_unit_assert.svh"

module mcdq_checker
  import mcdq_pkg::*;
#(
  parameter int NUM_QUEUES = 3
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic [OP_W-1:0]          operation,
  input logic [SEL_W-1:0]         queue_select,
  input logic                     strobe,
  input logic signed [WORD_W-1:0] element_value,
  input logic                     element_valid,
  input logic [INDEX_W-1:0]       head_index,
  input logic [INDEX_W-1:0]       tail_index,
  input logic                     last
);

  logic dump_taken;
  assign dump_taken = start && !busy && (operation == OP_DUMP) &&
                      (int'(queue_select) < NUM_QUEUES);

  `MCDQ_ASSERT_NOW(a_last_beat_clean, clk, rst, strobe && last, !element_valid && (element_value == '0), "closing beat carries an entry")
  `MCDQ_ASSERT_NOW(a_entry_beat_clean, clk, rst, strobe && element_valid, !last && (head_index == '0) && (tail_index == '0), "entry beat carries pointers")
  `MCDQ_ASSERT_NEXT(a_dump_holds_off, clk, rst, dump_taken, busy && !strobe, "dump did not raise busy")
  `MCDQ_ASSERT_ALWAYS(a_reset_quiet, clk, rst, !busy && !strobe, "not idle after reset")

endmodule

bind multi_circular_deque_unit mcdq_checker #(
  .NUM_QUEUES(NUM_QUEUES)
) u_mcdq_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .operation     (operation),
  .queue_select  (queue_select),
  .strobe        (strobe),
  .element_value (element_value),
  .element_valid (element_valid),
  .head_index    (head_index),
  .tail_index    (tail_index),
  .last          (last)
);
